### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both macros check on the rising clock edge and are disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every checked clock edge.
`define SPAQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a checked clock edge.
`define SPAQ_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SPAQ_ASSERT(label, clk, rst, prop, msg)
`define SPAQ_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

### rtl/spaq_pkg.sv
`default_nettype none

package spaq_pkg;

   localparam int CAPACITY  = 8;
   localparam int KEY_WIDTH = 16;
   localparam int CNT_WIDTH = $clog2(CAPACITY + 1);

   // Fixed widths of the item fields on the ports.
   localparam int KEY_FIELD_WIDTH = 16;
   localparam int OCC_FIELD_WIDTH = 4;
   localparam int RSP_DATA_WIDTH  = 24;

   typedef logic [KEY_WIDTH-1:0] key_type;
   typedef logic [CNT_WIDTH-1:0] count_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Operation broadcast to every cell of the row.
   typedef struct packed {
      logic    ins_en;
      logic    rem_en;
      key_type key;
   } ctrl_type;

endpackage

`default_nettype wire

### rtl/sorted_array_priority_queue.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tuser: command; tdata: key_in
// rsp       out        rsp_tvalid/rsp_tready  tuser: status; tdata: key_out, occupancy
//
// The whole row of cells updates in the cycle the item is accepted, and the
// result is registered for the next cycle.
// One item per cycle is sustained while results are taken; the single output
// register stalls input only when a result is waiting and rsp_tready is low.
// Reset clears the key count and the output valid; stored keys need no reset.

`include "assert_macros.svh"

module sorted_array_priority_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] key_in
   input  wire logic        req_tuser,   // [0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [15:0] key_out, [19:16] occupancy, [23:20] zero
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   localparam int CAP = spaq_pkg::CAPACITY;

   // Number of keys held; cell i is occupied when its index is below this.
   spaq_pkg::count_type count_ff;
   spaq_pkg::count_type count_in;

   // Result register that parts the two sides of the block.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [15:0]             rsp_key_ff;
   logic [15:0]             rsp_key_in;
   spaq_pkg::status_type    rsp_status_ff;
   spaq_pkg::status_type    rsp_status_in;
   logic [3:0]              rsp_occ_ff;
   logic [3:0]              rsp_occ_in;

   logic                    req_accept;
   logic                    is_full;
   logic                    is_empty;
   spaq_pkg::command_type   command;
   spaq_pkg::ctrl_type      ctrl;

   spaq_pkg::key_type       cell_key  [CAP];
   logic                    cell_gt   [CAP];
   logic                    cell_occ  [CAP];
   logic                    cell_pgt  [CAP];
   spaq_pkg::key_type       cell_pkey [CAP];
   spaq_pkg::key_type       cell_nkey [CAP];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign command    = spaq_pkg::command_type'(req_tuser);
   assign is_full    = (count_ff == spaq_pkg::CNT_WIDTH'(CAP));
   assign is_empty   = (count_ff == '0);

   always_comb begin
      ctrl.ins_en = req_accept && (command == spaq_pkg::CMD_INSERT) && !is_full;
      ctrl.rem_en = req_accept && (command == spaq_pkg::CMD_REMOVE) && !is_empty;
      ctrl.key    = spaq_pkg::key_type'(req_tdata);
   end

   // The row of cells. Each cell sees its lower neighbor for inserts and its
   // upper neighbor for removes; the ends are tied off.
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      assign cell_occ[i] = (count_ff > spaq_pkg::CNT_WIDTH'(i));

      if (i == 0) begin : g_first
         assign cell_pgt[i]  = 1'b0;
         assign cell_pkey[i] = cell_key[i];
      end else begin : g_inner
         assign cell_pgt[i]  = cell_gt[i-1];
         assign cell_pkey[i] = cell_key[i-1];
      end

      if (i == CAP - 1) begin : g_last
         assign cell_nkey[i] = cell_key[i];
      end else begin : g_below
         assign cell_nkey[i] = cell_key[i+1];
      end

      spaq_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .occupied (cell_occ[i]),
         .prev_gt  (cell_pgt[i]),
         .prev_key (cell_pkey[i]),
         .next_key (cell_nkey[i]),
         .gt       (cell_gt[i]),
         .key      (cell_key[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + spaq_pkg::CNT_WIDTH'(1);
      end else if (ctrl.rem_en) begin
         count_in = count_ff - spaq_pkg::CNT_WIDTH'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_key_in    = '0;
         rsp_status_in = spaq_pkg::STATUS_OK;
         rsp_occ_in    = 4'(count_in);
         case (command)
            spaq_pkg::CMD_INSERT: begin
               if (is_full) begin
                  rsp_status_in = spaq_pkg::STATUS_FULL;
               end
            end
            spaq_pkg::CMD_REMOVE: begin
               if (is_empty) begin
                  rsp_status_in = spaq_pkg::STATUS_EMPTY;
               end else begin
                  // The smallest key always sits in the first cell.
                  rsp_key_in = spaq_pkg::KEY_FIELD_WIDTH'(cell_key[0]);
               end
            end
            default: begin
               rsp_status_in = spaq_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_occ_ff, rsp_key_ff};
   assign rsp_tuser  = rsp_status_ff;

   `SPAQ_ASSERT_NEVER(a_count_bound, clock, reset,
      count_ff > spaq_pkg::CNT_WIDTH'(CAP), "key count exceeds capacity")

   `SPAQ_ASSERT(a_full_drop, clock, reset,
      (req_accept && command == spaq_pkg::CMD_INSERT && is_full) |=>
         (rsp_status_ff == spaq_pkg::STATUS_FULL && $stable(count_ff)),
      "dropped insert changed the count or was not flagged")

   `SPAQ_ASSERT(a_remove_key, clock, reset,
      ctrl.rem_en |=> (rsp_key_ff == spaq_pkg::KEY_FIELD_WIDTH'($past(cell_key[0]))),
      "removed key is not the one held in the first cell")

   `SPAQ_ASSERT(a_ordered_front, clock, reset,
      (count_ff > spaq_pkg::CNT_WIDTH'(1)) |-> (cell_key[0] <= cell_key[1]),
      "first two keys are out of order")

endmodule

`default_nettype wire

### rtl/spaq_cell.sv
`default_nettype none

// One slot of the sorted row. It holds one key and tells its upper neighbor
// whether that key is larger than the key being inserted.
module spaq_cell (
   input  wire logic               clock,
   input  wire spaq_pkg::ctrl_type ctrl,
   input  wire logic               occupied,
   input  wire logic               prev_gt,
   input  wire spaq_pkg::key_type  prev_key,
   input  wire spaq_pkg::key_type  next_key,
   output logic                    gt,
   output spaq_pkg::key_type       key
);

   spaq_pkg::key_type key_ff;
   spaq_pkg::key_type key_in;

   assign gt  = occupied && (key_ff > ctrl.key);
   assign key = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctrl.ins_en) begin
         // The lower neighbor moves up if it is larger; the first slot that is
         // larger or empty takes the new key.
         if (prev_gt) begin
            key_in = prev_key;
         end else if (gt || !occupied) begin
            key_in = ctrl.key;
         end
      end else if (ctrl.rem_en) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

`default_nettype wire
